// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the coalescer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, masked while reset is high
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked at every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/rbc_pkg.sv =====
// types and constants of the receive block coalescer
package rbc_pkg;

   // fixed field widths
   localparam int LEN_W  = 17;
   localparam int TIME_W = 32;
   localparam int LIM_W  = 20;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 88;

   // parameter defaults
   localparam int BLOCK_CAPACITY_DEF = 8 * 1024;
   localparam int MAX_CHUNK_DEF      = 65536;

   // register reset values
   localparam logic [LIM_W-1:0] IDLE_LIMIT_RST = LIM_W'(8 * 1000);
   localparam logic [LIM_W-1:0] MAX_WAIT_RST   = LIM_W'(24 * 1000);

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_COALESCE_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WAIT        = 2'd2;

   // operation codes
   localparam logic OP_CHUNK = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // source of an emitted block
   localparam logic [1:0] SRC_PEND = 2'd0;
   localparam logic [1:0] SRC_PASS = 2'd1;
   localparam logic [1:0] SRC_FILL = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       clock_inc;
      logic       fill_step;
      logic       emit;
      logic [1:0] emit_src;
      logic       push_last;
   } rbc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic enable;
      logic op_tick;
      logic left_zero;
      logic pend_zero;
      logic stg_valid;
      logic out_free;
      logic slot_ok;
      logic tick_close;
      logic age_close;
      logic fill_full;
      logic fill_left_zero;
   } rbc_sts_type;

endpackage

// ===== rtl/core/rbc_ctrl.sv =====
// sequencer of the receive block coalescer
`include "assert_macros.svh"

module rbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  rbc_pkg::rbc_sts_type sts,
   output rbc_pkg::rbc_cmd_type cmd
);
   import rbc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PRE  = 3'd1;
   localparam logic [2:0] S_TICK = 3'd2;
   localparam logic [2:0] S_PASS = 3'd3;
   localparam logic [2:0] S_FILL = 3'd4;
   localparam logic [2:0] S_AGE  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       pre_close;

   assign req_tready = (state_ff == S_IDLE);
   assign pre_close  = !sts.enable && !sts.pend_zero;

   always_comb begin
      cmd      = '0;
      cmd.emit_src = SRC_PEND;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            // coalescing off closes the pending block first
            if (!pre_close || sts.slot_ok) begin
               cmd.emit      = pre_close;
               cmd.clock_inc = sts.op_tick;
               if (sts.op_tick) begin
                  state_in = S_TICK;
               end else if (sts.left_zero) begin
                  state_in = S_DONE;
               end else if (sts.enable) begin
                  state_in = S_FILL;
               end else begin
                  state_in = S_PASS;
               end
            end
         end
         S_TICK: begin
            if (!sts.tick_close) begin
               state_in = S_DONE;
            end else if (sts.slot_ok) begin
               cmd.emit = 1'b1;
               state_in = S_DONE;
            end
         end
         S_PASS: begin
            if (sts.slot_ok) begin
               cmd.emit     = 1'b1;
               cmd.emit_src = SRC_PASS;
               state_in     = S_DONE;
            end
         end
         S_FILL: begin
            if (!sts.fill_full || sts.slot_ok) begin
               cmd.fill_step = 1'b1;
               cmd.emit      = sts.fill_full;
               cmd.emit_src  = SRC_FILL;
               if (sts.fill_left_zero) begin
                  state_in = S_AGE;
               end
            end
         end
         S_AGE: begin
            if (!sts.age_close) begin
               state_in = S_DONE;
            end else if (sts.slot_ok) begin
               cmd.emit = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!sts.stg_valid) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.push_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_SYNC(a_idle_stage_empty, clock, reset, req_tready |-> !sts.stg_valid, "new transaction while a block is still staged")
   `ASSERT_SYNC(a_fill_only_on, clock, reset, cmd.fill_step |-> sts.enable, "fill step with coalescing off")

endmodule

// ===== rtl/core/rbc_dp.sv =====
// registers, fill arithmetic and result staging of the receive block coalescer
`include "assert_macros.svh"

module rbc_dp #(
   parameter int BLOCK_CAPACITY = rbc_pkg::BLOCK_CAPACITY_DEF,
   parameter int MAX_CHUNK      = rbc_pkg::MAX_CHUNK_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_op,
   input  logic [rbc_pkg::LEN_W-1:0]     req_len,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [rbc_pkg::LEN_W-1:0]     rsp_len,
   output logic [rbc_pkg::TIME_W-1:0]    rsp_first,
   output logic [rbc_pkg::TIME_W-1:0]    rsp_last,
   output logic                          rsp_tlast,
   input  logic                          csr_wr_en,
   input  logic [rbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rbc_pkg::LIM_W-1:0]     csr_wdata,
   input  rbc_pkg::rbc_cmd_type          cmd,
   output rbc_pkg::rbc_sts_type          sts
);
   import rbc_pkg::*;

   localparam int PB_W = $clog2(BLOCK_CAPACITY + 1);
   localparam logic [PB_W-1:0]  CAP     = PB_W'(BLOCK_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_CHUNK);

   // configuration
   logic             enable_ff;
   logic [LIM_W-1:0] idle_limit_ff;
   logic [LIM_W-1:0] max_wait_ff;

   // item and block state
   logic              op_ff, op_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [TIME_W-1:0] clock_ff, clock_in;
   logic [PB_W-1:0]   pend_ff, pend_in;
   logic [TIME_W-1:0] first_ff, first_in;
   logic [TIME_W-1:0] last_ff, last_in;

   // staging slot and output register
   logic              stg_valid_ff, stg_valid_in;
   logic [LEN_W-1:0]  stg_len_ff, stg_len_in;
   logic [TIME_W-1:0] stg_first_ff, stg_first_in;
   logic [TIME_W-1:0] stg_last_ff, stg_last_in;
   logic              out_valid_ff, out_valid_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [TIME_W-1:0] out_first_ff, out_first_in;
   logic [TIME_W-1:0] out_last_ff, out_last_in;
   logic              out_tlast_ff, out_tlast_in;

   // fill step
   logic [PB_W-1:0]   room;
   logic [LEN_W-1:0]  room_ext;
   logic [LEN_W-1:0]  take;
   logic [PB_W-1:0]   fill_pend;
   logic [LEN_W-1:0]  fill_left;
   logic [TIME_W-1:0] fill_first;
   logic [TIME_W-1:0] idle_time;
   logic [TIME_W-1:0] age_time;
   logic              out_free;
   logic              age_hit;

   assign room       = CAP - pend_ff;
   assign room_ext   = LEN_W'(room);
   assign take       = (left_ff < room_ext) ? left_ff : room_ext;
   assign fill_pend  = pend_ff + PB_W'(take);
   assign fill_left  = left_ff - take;
   assign fill_first = (pend_ff == '0) ? clock_ff : first_ff;

   assign idle_time = clock_ff - last_ff;
   assign age_time  = clock_ff - first_ff;
   assign age_hit   = age_time >= TIME_W'(max_wait_ff);
   assign out_free  = !out_valid_ff || rsp_tready;

   always_comb begin
      sts.enable         = enable_ff;
      sts.op_tick        = (op_ff == OP_TICK);
      sts.left_zero      = (left_ff == '0);
      sts.pend_zero      = (pend_ff == '0);
      sts.stg_valid      = stg_valid_ff;
      sts.out_free       = out_free;
      sts.slot_ok        = !stg_valid_ff || out_free;
      sts.tick_close     = enable_ff && (pend_ff != '0) &&
                           ((idle_time >= TIME_W'(idle_limit_ff)) || age_hit);
      sts.age_close      = (pend_ff != '0) && age_hit;
      sts.fill_full      = (fill_pend == CAP);
      sts.fill_left_zero = (fill_left == '0);
   end

   always_comb begin
      op_in        = op_ff;
      left_in      = left_ff;
      clock_in     = clock_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      stg_valid_in = stg_valid_ff;
      stg_len_in   = stg_len_ff;
      stg_first_in = stg_first_ff;
      stg_last_in  = stg_last_ff;
      out_valid_in = out_valid_ff;
      out_len_in   = out_len_ff;
      out_first_in = out_first_ff;
      out_last_in  = out_last_ff;
      out_tlast_in = out_tlast_ff;

      if (cmd.load) begin
         op_in   = req_op;
         left_in = (req_len > LEN_SAT) ? LEN_SAT : req_len;
      end
      if (cmd.clock_inc) begin
         clock_in = clock_ff + 1'b1;
      end
      if (cmd.fill_step) begin
         pend_in  = fill_pend;
         left_in  = fill_left;
         first_in = fill_first;
         last_in  = clock_ff;
      end

      // output register drains, then may be refilled from the stage
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.push_last || (cmd.emit && stg_valid_ff)) begin
         out_valid_in = 1'b1;
         out_len_in   = stg_len_ff;
         out_first_in = stg_first_ff;
         out_last_in  = stg_last_ff;
         out_tlast_in = cmd.push_last;
      end
      if (cmd.push_last) begin
         stg_valid_in = 1'b0;
      end

      if (cmd.emit) begin
         stg_valid_in = 1'b1;
         case (cmd.emit_src)
            SRC_PEND: begin
               stg_len_in   = LEN_W'(pend_ff);
               stg_first_in = first_ff;
               stg_last_in  = last_ff;
            end
            SRC_PASS: begin
               stg_len_in   = left_ff;
               stg_first_in = clock_ff;
               stg_last_in  = clock_ff;
               left_in      = '0;
            end
            SRC_FILL: begin
               stg_len_in   = LEN_W'(fill_pend);
               stg_first_in = fill_first;
               stg_last_in  = clock_ff;
            end
            default: begin
               stg_len_in   = LEN_W'(pend_ff);
               stg_first_in = first_ff;
               stg_last_in  = last_ff;
            end
         endcase
         // a closed block leaves nothing pending
         if (cmd.emit_src != SRC_PASS) begin
            pend_in  = '0;
            first_in = '0;
            last_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         idle_limit_ff <= IDLE_LIMIT_RST;
         max_wait_ff   <= MAX_WAIT_RST;
         clock_ff      <= '0;
         pend_ff       <= '0;
         first_ff      <= '0;
         last_ff       <= '0;
         stg_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COALESCE_ENABLE: enable_ff     <= csr_wdata[0];
               CSR_IDLE_LIMIT:      idle_limit_ff <= csr_wdata;
               CSR_MAX_WAIT:        max_wait_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         clock_ff     <= clock_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      left_ff      <= left_in;
      stg_len_ff   <= stg_len_in;
      stg_first_ff <= stg_first_in;
      stg_last_ff  <= stg_last_in;
      out_len_ff   <= out_len_in;
      out_first_ff <= out_first_in;
      out_last_ff  <= out_last_in;
      out_tlast_ff <= out_tlast_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_len    = out_len_ff;
   assign rsp_first  = out_first_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_tlast  = out_tlast_ff;

   `ASSERT_SYNC(a_pend_below_cap, clock, reset, pend_ff < CAP, "pending block at capacity")
   `ASSERT_SYNC(a_push_needs_stage, clock, reset, cmd.push_last |-> stg_valid_ff,
      "final transaction pushed from an empty stage")
   `ASSERT_SYNC(a_no_overwrite, clock, reset, (cmd.emit && stg_valid_ff) |-> out_free,
      "staged block moved onto a result still waiting")

endmodule

// ===== rtl/core/receive_block_coalescer.sv =====
// top level of the receive block coalescer
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser operation, tdata chunk_length
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata block fields, tlast last_of_run
//  csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// one transaction at a time: accept, pre-close, work, final push
// a tick has a tick check, a pass-through chunk a pass step, an empty chunk no work step, a coalesced
// chunk a fill step for each block it touches (up to MAX_CHUNK / BLOCK_CAPACITY + 1) and an age check
// each result is held one step in a staging slot so the final one can carry tlast;
// the rsp register stalls the sequencer only when a new block must leave the stage
// synchronous active-high reset clears the clock, the pending block and both result slots

module receive_block_coalescer #(
   parameter int BLOCK_CAPACITY = rbc_pkg::BLOCK_CAPACITY_DEF,
   parameter int MAX_CHUNK      = rbc_pkg::MAX_CHUNK_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rbc_pkg::REQ_DATA_W-1:0] req_tdata,  // chunk_length[16:0], zero pad
   input  logic                           req_tuser,  // operation[0]
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rbc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // block_length[16:0],
                                                      // first_time[48:17],
                                                      // last_time[80:49], zero pad
   output logic                           rsp_tlast,  // last_of_run
   // register writes
   input  logic                           csr_wr_en,
   input  logic [rbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbc_pkg::LIM_W-1:0]      csr_wdata
);
   import rbc_pkg::*;

   rbc_cmd_type       cmd;
   rbc_sts_type       sts;
   logic [LEN_W-1:0]  rsp_len;
   logic [TIME_W-1:0] rsp_first;
   logic [TIME_W-1:0] rsp_last;

   // sequencer: walks each transaction through its close, tick, pass, fill and age steps
   rbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: clock counter, pending block, split arithmetic, result slots
   rbc_dp #(
      .BLOCK_CAPACITY (BLOCK_CAPACITY),
      .MAX_CHUNK      (MAX_CHUNK)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_len    (req_tdata[LEN_W-1:0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_len    (rsp_len),
      .rsp_first  (rsp_first),
      .rsp_last   (rsp_last),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // pack the block fields low to high, pad to whole bytes
   assign rsp_tdata = {{(RSP_DATA_W - LEN_W - 2 * TIME_W){1'b0}}, rsp_last, rsp_first, rsp_len};

endmodule

// ===== tb/sv/rbc_checker.sv =====
// checker for the receive block coalescer: predicts closed blocks and compares each result
module rbc_checker #(
   parameter int BLOCK_CAPACITY = rbc_pkg::BLOCK_CAPACITY_DEF,
   parameter int MAX_CHUNK      = rbc_pkg::MAX_CHUNK_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rbc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [rbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbc_pkg::LIM_W-1:0]      csr_wdata,
   output int                             fail_count,
   output int                             blocks_waiting,
   output int                             blocks_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import rbc_pkg::*;

   typedef struct packed {
      logic [LEN_W-1:0]  length;
      logic [TIME_W-1:0] first_time;
      logic [TIME_W-1:0] last_time;
      logic              last_of_run;
   } block_type;

   localparam int MAX_REPORTS = 40;

   // predicted registers and block state
   logic              coalesce_on;
   logic [LIM_W-1:0]  idle_limit_q;
   logic [LIM_W-1:0]  max_wait_q;
   logic [TIME_W-1:0] now_ticks;
   logic [TIME_W-1:0] open_first;
   logic [TIME_W-1:0] open_last;
   int unsigned       open_bytes;

   block_type expected_blocks[$];
   int        errors = 0;
   int        checked = 0;

   function void add_block(input int unsigned len, input logic [TIME_W-1:0] first,
                           input logic [TIME_W-1:0] last);
      block_type b;
      b.length      = LEN_W'(len);
      b.first_time  = first;
      b.last_time   = last;
      b.last_of_run = 1'b0;
      expected_blocks = {expected_blocks, b};
   endfunction

   function void close_open_block();
      if (open_bytes == 0) return;
      add_block(open_bytes, open_first, open_last);
      open_bytes = 0;
      open_first = '0;
      open_last  = '0;
   endfunction

   function void predict_blocks(input logic op, input logic [LEN_W-1:0] raw_len);
      int unsigned       start_n;
      int unsigned       len;
      int unsigned       left;
      int unsigned       room;
      int unsigned       take;
      logic [TIME_W-1:0] idle_ticks;
      logic [TIME_W-1:0] age_ticks;
      start_n = expected_blocks.size();
      len = (raw_len > MAX_CHUNK) ? MAX_CHUNK : raw_len;
      if (!coalesce_on) close_open_block();
      if (op == OP_TICK) begin
         now_ticks = now_ticks + 1;
         if (coalesce_on && open_bytes != 0) begin
            idle_ticks = now_ticks - open_last;
            age_ticks  = now_ticks - open_first;
            if (idle_ticks >= TIME_W'(idle_limit_q) || age_ticks >= TIME_W'(max_wait_q))
               close_open_block();
         end
      end else if (len != 0) begin
         if (!coalesce_on) begin
            add_block(len, now_ticks, now_ticks);
         end else begin
            left = len;
            while (left != 0) begin
               if (open_bytes == 0) open_first = now_ticks;
               room = BLOCK_CAPACITY - open_bytes;
               take = (left < room) ? left : room;
               open_bytes += take;
               left -= take;
               open_last = now_ticks;
               if (open_bytes >= BLOCK_CAPACITY) close_open_block();
            end
            age_ticks = now_ticks - open_first;
            if (open_bytes != 0 && age_ticks >= TIME_W'(max_wait_q)) close_open_block();
         end
      end
      // the newest block of this transaction carries tlast
      if (expected_blocks.size() > start_n)
         expected_blocks[expected_blocks.size() - 1].last_of_run = 1'b1;
   endfunction

   function void report_mismatch(input string field, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
   endfunction

   function void check_block();
      block_type want;
      block_type got;
      got.length      = rsp_tdata[LEN_W-1:0];
      got.first_time  = rsp_tdata[LEN_W +: TIME_W];
      got.last_time   = rsp_tdata[LEN_W+TIME_W +: TIME_W];
      got.last_of_run = rsp_tlast;
      if (expected_blocks.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t mismatch: expected no block, actual block of length %0d",
                     $time, got.length);
         return;
      end
      want = expected_blocks.pop_front();
      checked++;
      if (want.length != got.length)
         report_mismatch("block_length", TIME_W'(want.length), TIME_W'(got.length));
      if (want.first_time != got.first_time)
         report_mismatch("first_time", want.first_time, got.first_time);
      if (want.last_time != got.last_time)
         report_mismatch("last_time", want.last_time, got.last_time);
      if (want.last_of_run != got.last_of_run)
         report_mismatch("last_of_run", TIME_W'(want.last_of_run), TIME_W'(got.last_of_run));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         coalesce_on  = 1'b0;
         idle_limit_q = IDLE_LIMIT_RST;
         max_wait_q   = MAX_WAIT_RST;
         now_ticks    = '0;
         open_first   = '0;
         open_last    = '0;
         open_bytes   = 0;
         expected_blocks.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_block();
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COALESCE_ENABLE: coalesce_on = csr_wdata[0];
               CSR_IDLE_LIMIT: idle_limit_q = csr_wdata;
               CSR_MAX_WAIT: max_wait_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_blocks(req_tuser, req_tdata[LEN_W-1:0]);
      end
      fail_count     <= errors;
      blocks_waiting <= expected_blocks.size();
      blocks_checked <= checked;
   end

endmodule

// ===== tb/sv/receive_block_coalescer_tb.sv =====
// testbench top of the receive block coalescer: stimulus, pacing and verdict
module receive_block_coalescer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rbc_pkg::*;

   // settle pause; an item with no result finishes well within it
   localparam int SETTLE_CYCLES  = 30;
   // quiet stretches come from sender gaps, result stalls and settle pauses, well under this
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 75;
   localparam logic [LIM_W-1:0] LIM_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_ALL_ONES = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_CHUNK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_COALESCE_ENABLE;
   logic [LIM_W-1:0]      csr_wdata = '0;

   int fail_count;
   int blocks_waiting;
   int blocks_checked;

   // pacing controls, changed per phase
   logic gaps_on = 1'b1;
   logic stalls_on = 1'b1;
   int   stall_left = 0;
   int   quiet_cycles = 0;

   int chunks_sent = 0;
   int ticks_sent = 0;
   int settings_used = 0;

   receive_block_coalescer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rbc_checker block_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .blocks_waiting (blocks_waiting),
      .blocks_checked (blocks_checked)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap(input logic enabled);
      int unsigned r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      else if (r < 93) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // chunk sizes: mostly under a block, some spanning several, a few oversized
   function automatic logic [LEN_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      else if (r < 70) return LEN_W'($urandom_range(1, 4000));
      else if (r < 90) return LEN_W'($urandom_range(4001, 20000));
      else if (r < 97) return LEN_W'($urandom_range(20001, MAX_CHUNK_DEF));
      else return LEN_W'($urandom_range(MAX_CHUNK_DEF + 1, 2 ** LEN_W - 1));
   endfunction

   // limits: mostly short so time-based closes happen often, plus zero, the top value and any value
   function automatic logic [LIM_W-1:0] pick_limit(input int unsigned short_top);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return LIM_W'($urandom_range(1, short_top));
      else if (r < 80) return '0;
      else if (r < 90) return LIM_MAX;
      else return LIM_W'($urandom_range(1, 2 ** LIM_W - 1));
   endfunction

   // result side: random stalls on rsp_tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0) stall_left = pick_gap(stalls_on);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: cycles without any transaction on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one request transaction, then an optional gap with tvalid low
   task automatic send_item(input logic op, input logic [LEN_W-1:0] len);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - LEN_W){1'b0}}, len};
      do @(posedge clock); while (!req_tready);
      if (op == OP_TICK) ticks_sent++;
      else chunks_sent++;
      gap = pick_gap(gaps_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_chunk(input logic [LEN_W-1:0] len);
      send_item(OP_CHUNK, len);
   endtask

   // tick with a random length field, which the block ignores
   task automatic send_tick();
      send_item(OP_TICK, LEN_W'($urandom_range(0, 2 ** LEN_W - 1)));
   endtask

   // hold the sender until every predicted block has arrived, plus extra cycles
   task automatic wait_drained(input int extra);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blocks_waiting != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // all three registers, written back to back once the block is idle
   task automatic change_settings(input logic enable, input logic [LIM_W-1:0] idle_lim,
                                  input logic [LIM_W-1:0] wait_lim);
      wait_drained(SETTLE_CYCLES);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_COALESCE_ENABLE;
      csr_wdata <= {{(LIM_W - 1){1'b0}}, enable};
      @(posedge clock);
      csr_index <= CSR_IDLE_LIMIT;
      csr_wdata <= idle_lim;
      @(posedge clock);
      csr_index <= CSR_MAX_WAIT;
      csr_wdata <= wait_lim;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass-through with reset settings: smallest, zero, largest and oversized chunks, then a tick
      send_chunk(LEN_W'(1));
      send_chunk('0);
      send_chunk(LEN_W'(MAX_CHUNK_DEF));
      send_chunk(LEN_ALL_ONES);
      send_tick();

      // coalescing with the top limits: exact fill, split across blocks, ignored empty chunk
      change_settings(1'b1, LIM_MAX, LIM_MAX);
      send_chunk(LEN_W'(BLOCK_CAPACITY_DEF));
      send_chunk(LEN_W'(100));
      send_tick();
      send_chunk(LEN_W'(MAX_CHUNK_DEF));
      send_chunk('0);

      // turning coalescing off closes the open block on a tick or an empty chunk
      change_settings(1'b0, LIM_MAX, LIM_MAX);
      send_tick();
      send_chunk(LEN_W'(7));
      change_settings(1'b1, LIM_MAX, LIM_MAX);
      send_chunk(LEN_W'(5));
      change_settings(1'b0, LIM_MAX, LIM_MAX);
      send_chunk('0);

      // zero limits: every open block closes at the first chance
      change_settings(1'b1, '0, '0);
      send_chunk(LEN_W'(10));
      send_tick();
      send_chunk(LEN_W'(9000));

      // short limits: idle close first, then age close while data keeps coming
      change_settings(1'b1, LIM_W'(3), LIM_W'(4));
      send_chunk(LEN_W'(1));
      repeat (3) send_tick();
      repeat (4) begin
         send_chunk(LEN_W'(1));
         send_tick();
      end

      // random phases, each under its own settings and pacing
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         change_settings((phase == 2) ? 1'b0 : ($urandom_range(0, 4) != 0),
                         pick_limit(12), pick_limit(30));
         gaps_on   <= (phase % 3 != 1);
         stalls_on <= (phase % 3 != 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // now and then the sender waits for the result stream to empty
            if ($urandom_range(0, 39) == 0) wait_drained(0);
            if ($urandom_range(0, 99) < 55) send_tick();
            else send_chunk(pick_length());
         end
      end

      wait_drained(SETTLE_CYCLES);
      $display("summary: %0d chunks and %0d ticks sent under %0d register settings",
               chunks_sent, ticks_sent, settings_used);
      $display("summary: %0d closed blocks compared field by field", blocks_checked);
      if (fail_count == 0 && blocks_waiting == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rbc_pkg.sv
rtl/core/rbc_ctrl.sv
rtl/core/rbc_dp.sv
rtl/core/receive_block_coalescer.sv
tb/sv/rbc_checker.sv
tb/sv/receive_block_coalescer_tb.sv
